/* rtl/lz78sc_pkg.sv */
// Shared types and constants for the LZ78 stream compressor.
// No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps

package lz78sc_pkg;

    // Width of a dictionary id; the chain holds one cell per non-root id.
    localparam int NODE_BITS = 10;
    localparam int NUM_CELLS = (1 << NODE_BITS) - 1;
    localparam logic [NODE_BITS-1:0] MAX_ID = {NODE_BITS{1'b1}};
    localparam logic [NODE_BITS-1:0] ROOT_ID = '0;
    localparam logic [NODE_BITS-1:0] FIRST_ID = {{(NODE_BITS-1){1'b0}}, 1'b1};

    // Fixed widths of the output word fields.
    localparam int INDEX_BITS = 10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_BITS-1:0] phrase_index;
        logic [7:0]            next_byte;
        logic                  no_byte;
        logic                  last_pair;
    } t_out_word;

    // One dictionary entry as held in a cell.
    typedef struct packed {
        logic                 valid;
        logic [NODE_BITS-1:0] id;
        logic [NODE_BITS-1:0] parent;
        logic [7:0]           last_byte;
    } t_cell_entry;

    // Fit a node id into the phrase_index field (zero-extend or truncate).
    function automatic logic [INDEX_BITS-1:0] to_phrase_index(
        input logic [NODE_BITS-1:0] node
    );
        logic [NODE_BITS+INDEX_BITS-1:0] ext;
        ext = {{INDEX_BITS{1'b0}}, node};
        return ext[INDEX_BITS-1:0];
    endfunction

endpackage

/* rtl/lz78sc_cell.sv */
// One dictionary cell: holds an entry, takes its neighbor's entry on insert,
// and matches (node, byte) against it. Depends on lz78sc_pkg.
`timescale 1ns / 1ps

module lz78sc_cell import lz78sc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic                 i_clear,
    input  t_cell_entry          i_prev,
    input  logic [NODE_BITS-1:0] i_node,
    input  logic [7:0]           i_byte,
    output t_cell_entry          o_entry,
    output logic [NODE_BITS-1:0] o_hit_id
);

    logic                 r_valid;
    logic [NODE_BITS-1:0] r_id;
    logic [NODE_BITS-1:0] r_parent;
    logic [7:0]           r_byte;

    // Drop the entry on clear, take the neighbor's entry on insert
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_id     <= i_prev.id;
            r_parent <= i_prev.parent;
            r_byte   <= i_prev.last_byte;
        end
    end

    assign o_entry = '{valid: r_valid, id: r_id, parent: r_parent, last_byte: r_byte};

    // Report own id on a match, zero otherwise
    always_comb begin
        if (r_valid && (r_parent == i_node) && (r_byte == i_byte)) begin
            o_hit_id = r_id;
        end else begin
            o_hit_id = ROOT_ID;
        end
    end

endmodule

/* rtl/lz78sc_dict.sv */
// Dictionary as a chain of lz78sc_cell; new entries enter at the head and
// shift down. Combines the per-cell match ids. Depends on lz78sc_pkg.
`timescale 1ns / 1ps

module lz78sc_dict import lz78sc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_insert,
    input  logic                 i_clear,
    input  logic [NODE_BITS-1:0] i_new_id,
    input  logic [NODE_BITS-1:0] i_new_parent,
    input  logic [7:0]           i_new_byte,
    input  logic [NODE_BITS-1:0] i_node,
    input  logic [7:0]           i_byte,
    output logic [NODE_BITS-1:0] o_child
);

    // Tail entry falls off only when the chain is full, which never shifts
    t_cell_entry          w_chain [0:NUM_CELLS];
    logic [NODE_BITS-1:0] w_hit   [0:NUM_CELLS-1];

    // Head of the chain carries the entry being inserted
    assign w_chain[0] = '{valid: 1'b1, id: i_new_id, parent: i_new_parent,
                          last_byte: i_new_byte};

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        lz78sc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (i_insert),
            .i_clear  (i_clear),
            .i_prev   (w_chain[k]),
            .i_node   (i_node),
            .i_byte   (i_byte),
            .o_entry  (w_chain[k+1]),
            .o_hit_id (w_hit[k])
        );
    end

    // Entries are unique, so at most one cell hits; merge the ids
    always_comb begin
        o_child = ROOT_ID;
        for (int k = 0; k < NUM_CELLS; k++) begin
            o_child = o_child | w_hit[k];
        end
    end

endmodule

/* rtl/lz78_stream_compressor.sv */
// LZ78 stream compressor top level: trie walk control, dictionary chain and
// output register with skid stage. Depends on lz78sc_pkg, lz78sc_dict.
// Throughput: one byte per cycle while the skid stage is empty, set by the
// combinational match of (current node, byte) across all cells feeding
// the walk register. Pairs go to the output register, or the skid stage on a stall.
// Reset: walk returns to the root, ids restart at 1, every cell is emptied at once.
`timescale 1ns / 1ps

module lz78_stream_compressor import lz78sc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic [NODE_BITS-1:0] r_node, n_node;
    logic [NODE_BITS-1:0] r_next_id, n_next_id;
    logic                 r_full, n_full;
    logic                 r_out_valid, r_skid_valid;
    t_out_word            r_out_word, r_skid_word;

    logic                 w_accept;
    logic [NODE_BITS-1:0] w_child;
    logic                 w_hit;
    logic                 w_insert;
    logic                 w_clear;
    logic                 w_emit;
    t_out_word            w_pair;
    logic                 w_out_take;

    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_hit      = (w_child != ROOT_ID);

    lz78sc_dict u_dict (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_insert     (w_insert),
        .i_clear      (w_clear),
        .i_new_id     (r_next_id),
        .i_new_parent (r_node),
        .i_new_byte   (i_in_word.data_byte),
        .i_node       (r_node),
        .i_byte       (i_in_word.data_byte),
        .o_child      (w_child)
    );

    // Walk the trie: follow a hit; miss emits, inserts unless full; end emits, restarts
    always_comb begin
        n_node    = r_node;
        n_next_id = r_next_id;
        n_full    = r_full;
        w_insert  = 1'b0;
        w_clear   = 1'b0;
        w_emit    = 1'b0;
        w_pair    = '{phrase_index: to_phrase_index(r_node),
                      next_byte: i_in_word.data_byte, no_byte: 1'b0,
                      last_pair: i_in_word.end_of_data};
        if (w_accept) begin
            if (w_hit && !i_in_word.end_of_data) begin
                n_node = w_child;
            end else if (w_hit) begin
                w_emit = 1'b1;
                w_pair = '{phrase_index: to_phrase_index(w_child), next_byte: 8'd0,
                           no_byte: 1'b1, last_pair: 1'b1};
            end else begin
                w_emit = 1'b1;
            end
            if (w_emit && i_in_word.end_of_data) begin
                w_clear   = 1'b1;
                n_node    = ROOT_ID;
                n_next_id = FIRST_ID;
                n_full    = 1'b0;
            end else if (w_emit) begin
                n_node = ROOT_ID;
                if (!r_full) begin
                    w_insert = 1'b1;
                    if (r_next_id == MAX_ID) begin
                        n_full = 1'b1;
                    end else begin
                        n_next_id = r_next_id + FIRST_ID;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node    <= ROOT_ID;
            r_next_id <= FIRST_ID;
            r_full    <= 1'b0;
        end else begin
            r_node    <= n_node;
            r_next_id <= n_next_id;
            r_full    <= n_full;
        end
    end

    // Output register with skid stage
    assign w_out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_emit) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out_word <= r_skid_word;
            end
        end else if (w_emit) begin
            if (!r_out_valid || w_out_take) begin
                r_out_word <= w_pair;
            end else begin
                r_skid_word <= w_pair;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* sim/lz78_pair_checker.sv */
// Scoreboard for the LZ78 stream compressor: predicts phrase pairs from the
// accepted input words and compares them with the output words. Uses lz78sc_pkg.
`timescale 1ns / 1ps

module lz78_pair_checker import lz78sc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    // Trie as seen by the predictor: (parent, byte) -> child id.
    logic [NODE_BITS-1:0] walk_node;
    logic [NODE_BITS-1:0] free_id;
    logic                 dict_full;
    logic [NODE_BITS-1:0] child_of [logic [NODE_BITS+7:0]];

    t_out_word expected_pairs[$];
    int        fail_count = 0;
    int        pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Empty the dictionary and return the walk to the root.
    task automatic clear_dictionary();
        walk_node = ROOT_ID;
        free_id   = FIRST_ID;
        dict_full = 1'b0;
        child_of.delete();
    endtask

    // Walk the trie with one byte; report the pair it emits, if any.
    task automatic encode_byte(input t_in_word w, output bit emits, output t_out_word pair);
        logic [NODE_BITS+7:0] key;
        key   = {walk_node, w.data_byte};
        pair  = '0;
        emits = 1'b1;
        if (child_of.exists(key)) begin
            if (!w.end_of_data) begin
                // Extend the phrase, nothing to emit yet.
                walk_node = child_of[key];
                emits = 1'b0;
            end else begin
                // Stream ends inside a phrase: emit it with no following byte.
                pair.phrase_index = INDEX_BITS'(child_of[key]);
                pair.no_byte      = 1'b1;
                pair.last_pair    = 1'b1;
                clear_dictionary();
            end
        end else begin
            pair.phrase_index = INDEX_BITS'(walk_node);
            pair.next_byte    = w.data_byte;
            pair.last_pair    = w.end_of_data;
            if (w.end_of_data) begin
                clear_dictionary();
            end else begin
                // Add the new phrase unless every id is taken.
                if (!dict_full) begin
                    child_of[key] = free_id;
                    if (free_id == MAX_ID) begin
                        dict_full = 1'b1;
                    end else begin
                        free_id = free_id + 1'b1;
                    end
                end
                walk_node = ROOT_ID;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, actual %0d", field, want_v, got_v);
            fail_count++;
        end
    endtask

    initial clear_dictionary();

    // Predict on every accepted input word, compare on every accepted output word.
    always @(posedge i_clk) begin : scoreboard
        bit        emits;
        t_out_word pair;
        t_out_word want;
        if (!i_rst_n) begin
            clear_dictionary();
            expected_pairs.delete();
            pending_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                encode_byte(i_in_word, emits, pair);
                if (emits) begin
                    expected_pairs = {expected_pairs, pair};
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pairs.size() == 0) begin
                    $error("output word with no pair expected: index %0d byte %0d",
                           i_out_word.phrase_index, i_out_word.next_byte);
                    fail_count++;
                end else begin
                    want = expected_pairs.pop_front();
                    check_field("phrase_index", 32'(want.phrase_index),
                                32'(i_out_word.phrase_index));
                    check_field("next_byte", 32'(want.next_byte),
                                32'(i_out_word.next_byte));
                    check_field("no_byte", 32'(want.no_byte),
                                32'(i_out_word.no_byte));
                    check_field("last_pair", 32'(want.last_pair),
                                32'(i_out_word.last_pair));
                end
            end
            pending_count = expected_pairs.size();
        end
    end

endmodule

/* sim/lz78_stream_compressor_tb.sv */
// Testbench top for the LZ78 stream compressor: clock, reset, byte streams and
// random stalls on both channels. Uses lz78sc_pkg and lz78_pair_checker.
`timescale 1ns / 1ps

module lz78_stream_compressor_tb;
    import lz78sc_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int FILL_BYTES   = 900;

    logic      i_clk     = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    bit        idle_on = 1'b1;

    always #5 i_clk = ~i_clk;

    lz78_stream_compressor dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    lz78_pair_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("lz78_stream_compressor regression: fail");
            $finish;
        end
    end

    // Offer one byte after a random gap and hold it until accepted.
    task automatic send_word(input logic [7:0] b, input logic eod);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{data_byte: b, end_of_data: eod};
        do @(posedge i_clk); while (in_stall);
    endtask

    // Send one stream; span 0 draws from all bytes, else from a few random ones.
    task automatic send_stream(input int len, input int span);
        logic [7:0] alphabet[4];
        logic [7:0] b;
        foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(0, 255));
        idle_on = ($urandom_range(0, 3) != 0);
        for (int n = 0; n < len; n++) begin
            b = (span == 0) ? 8'($urandom_range(0, 255)) : alphabet[$urandom_range(0, span - 1)];
            send_word(b, n == len - 1);
        end
    endtask

    // Output side: random stalls, plus two long hold-offs to back the block up.
    initial begin : output_side
        int taken;
        int hold;
        taken = 0;
        wait (rst_n);
        forever begin
            if (taken == 150 || taken == 700) begin
                hold = HOLD_CYCLES;
            end else begin
                hold = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!out_valid);
            taken++;
        end
    end

    initial begin : input_side
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Miss on the final byte from the root, at the low byte extreme.
        send_word(8'h00, 1'b1);
        // Match on the final byte: ends inside phrase 1.
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        // Repeated byte grows a two-deep phrase, stream ends inside it.
        repeat (4) send_word(8'h41, 1'b0);
        send_word(8'h41, 1'b1);
        // Miss on the final byte after a matched prefix.
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b1);

        // Long random stream that builds a large dictionary.
        send_stream(FILL_BYTES, 0);

        // Short streams, mostly over tiny alphabets so phrases get long.
        for (int s = 0; s < 20; s++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_stream($urandom_range(1, 24), 0);
            end else begin
                send_stream($urandom_range(1, 24), $urandom_range(1, 4));
            end
        end
        in_valid <= 1'b0;

        // Let the scoreboard see the last word, drain, then give the block its latency.
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("lz78_stream_compressor regression: pass");
        end else begin
            $display("lz78_stream_compressor regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/lz78sc_pkg.sv
rtl/lz78sc_cell.sv
rtl/lz78sc_dict.sv
rtl/lz78_stream_compressor.sv
sim/lz78_pair_checker.sv
sim/lz78_stream_compressor_tb.sv
